### sv/index_allocator_with_reservation_core_defines.svh
// Assertion helpers shared by the allocator RTL.
`ifndef INDEX_ALLOCATOR_WITH_RESERVATION_CORE_DEFINES_SVH
`define INDEX_ALLOCATOR_WITH_RESERVATION_CORE_DEFINES_SVH

// Condition holds at every clock edge outside reset.
`define IAR_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define IAR_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define IAR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/iar_pkg.sv
package iar_pkg;

   // Default number of indices tracked
   localparam int IAR_CAPACITY = 256;

   // Bitmap words hold 32 indices each
   localparam int IAR_WORD_W = 32;
   localparam int IAR_BIT_W  = 5;

   // Beat layouts
   localparam int IAR_REQ_W = 16;
   localparam int IAR_RSP_W = 16;
   localparam int IAR_GRANT_W = 8;

   typedef enum logic [1:0] {
      CMD_CLAIM        = 2'd0,
      CMD_CLAIM_FREE   = 2'd1,
      CMD_RESERVE      = 2'd2,
      CMD_RESERVE_FREE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_IN_USE       = 3'd1,
      ST_RESERVE_USED = 3'd2,
      ST_RANGE        = 3'd3,
      ST_FULL         = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FETCH,
      S_CHECK,
      S_RESP
   } state_type;

   // Result of the free-bit search over one bitmap word
   typedef struct packed {
      logic                 hit;
      logic [IAR_BIT_W-1:0] pos;
   } scan_res_type;

endpackage

### sv/index_allocator_with_reservation_core.sv
// Channel   Dir  Beat fields (low bit up)
// req_      in   tdata: command[1:0], index[10:2]
// rsp_      out  tdata: granted_index[7:0], status[10:8]
//
// Given index: accept, fetch, check, respond, then the next accept; beyond the
// capacity: accept, then respond. The response beat is registered on leaving respond.
// Lowest free: the single search unit walks the used bitmap one 32-bit word per
// cycle in the check step, until it finds a free bit or reaches the last word.
// Reset clears both bitmaps at once through per-word valid flops; no sweep.
// A stalled response holds the next command in its final step.
module index_allocator_with_reservation_core #(
   parameter int CAPACITY = iar_pkg::IAR_CAPACITY
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [iar_pkg::IAR_REQ_W-1:0] req_tdata,   // command[1:0], index[10:2]
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [iar_pkg::IAR_RSP_W-1:0] rsp_tdata    // granted_index[7:0], status[10:8]
);
   import iar_pkg::*;

   `include "index_allocator_with_reservation_core_defines.svh"

   localparam int NW = (CAPACITY + IAR_WORD_W - 1) / IAR_WORD_W;
   localparam int WA = (NW > 1) ? $clog2(NW) : 1;
   localparam int BW = WA + IAR_BIT_W;
   localparam logic [WA-1:0] LAST = WA'(NW - 1);

   state_type             state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [WA-1:0]         chk_addr_ff, chk_addr_in;
   logic [WA-1:0]         rd_addr_ff, rd_addr_in;
   logic [IAR_BIT_W-1:0]  bit_ff, bit_in;
   logic                  rd_vld_ff;
   logic [NW-1:0]         vld_ff, vld_in;
   logic [IAR_GRANT_W-1:0] res_grant_ff, res_grant_in;
   status_type            res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IAR_RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   cmd_type               req_cmd;
   logic [8:0]            req_index;
   logic [BW-1:0]         req_bits;
   logic                  req_accept;
   logic                  req_scan;
   logic                  req_range_err;
   logic                  scan_cmd;
   logic                  out_free;

   logic [IAR_WORD_W-1:0] used_q, rsv_q;
   logic [IAR_WORD_W-1:0] used_word, rsv_word;
   logic [IAR_WORD_W-1:0] used_wdata, rsv_wdata;
   logic [IAR_WORD_W-1:0] bit_mask;
   logic [IAR_BIT_W-1:0]  bit_sel;
   logic                  map_we;
   scan_res_type          scan_res;

   // Unpack the request beat
   assign req_cmd       = cmd_type'(req_tdata[1:0]);
   assign req_index     = req_tdata[10:2];
   assign req_bits      = BW'(req_index);
   assign req_tready    = (state_ff == S_IDLE);
   assign req_accept    = req_tvalid && req_tready;
   assign req_scan      = (req_cmd == CMD_CLAIM_FREE) || (req_cmd == CMD_RESERVE_FREE);
   assign req_range_err = !req_scan && (32'(req_index) >= 32'(CAPACITY));
   assign scan_cmd      = (cmd_ff == CMD_CLAIM_FREE) || (cmd_ff == CMD_RESERVE_FREE);
   assign out_free      = !rsp_valid_ff || rsp_tready;

   // Bitmap words; a never-written word reads as all free
   iar_ram #(.WIDTH(IAR_WORD_W), .DEPTH(NW)) u_used_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (chk_addr_ff),
      .wr_data (used_wdata),
      .rd_addr (rd_addr_ff),
      .rd_data (used_q)
   );

   iar_ram #(.WIDTH(IAR_WORD_W), .DEPTH(NW)) u_rsv_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (chk_addr_ff),
      .wr_data (rsv_wdata),
      .rd_addr (rd_addr_ff),
      .rd_data (rsv_q)
   );

   assign used_word = rd_vld_ff ? used_q : '0;
   assign rsv_word  = rd_vld_ff ? rsv_q  : '0;

   // Shared free-bit search over the word under check
   iar_ffz #(.CAPACITY(CAPACITY), .WA(WA)) u_ffz (
      .word_addr (chk_addr_ff),
      .used_word (used_word),
      .res       (scan_res)
   );

   // Bit to set: search result or the requested bit
   assign bit_sel  = scan_cmd ? scan_res.pos : bit_ff;
   assign bit_mask = IAR_WORD_W'(1) << bit_sel;

   // Updated words for a successful command
   always_comb begin
      used_wdata = used_word | bit_mask;
      case (cmd_ff)
         CMD_CLAIM:        rsv_wdata = rsv_word & ~bit_mask;
         CMD_CLAIM_FREE:   rsv_wdata = rsv_word;
         CMD_RESERVE:      rsv_wdata = rsv_word | bit_mask;
         CMD_RESERVE_FREE: rsv_wdata = rsv_word | bit_mask;
         default:          rsv_wdata = rsv_word;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = req_range_err ? S_RESP : S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!scan_cmd || scan_res.hit || (chk_addr_ff == LAST)) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and outputs per state
   always_comb begin
      cmd_in        = cmd_ff;
      chk_addr_in   = chk_addr_ff;
      rd_addr_in    = rd_addr_ff;
      bit_in        = bit_ff;
      res_grant_in  = res_grant_ff;
      res_status_in = res_status_ff;
      vld_in        = vld_ff;
      map_we        = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            // Latch the command and aim the read at its word
            if (req_accept) begin
               cmd_in        = req_cmd;
               res_grant_in  = '0;
               res_status_in = req_range_err ? ST_RANGE : ST_OK;
               if (req_scan || req_range_err) begin
                  chk_addr_in = '0;
                  rd_addr_in  = '0;
                  bit_in      = '0;
               end else begin
                  chk_addr_in = req_bits[BW-1:IAR_BIT_W];
                  rd_addr_in  = req_bits[BW-1:IAR_BIT_W];
                  bit_in      = req_bits[IAR_BIT_W-1:0];
               end
            end
         end
         S_FETCH: begin
            // Prefetch the next word while the first one arrives
            if (scan_cmd && (rd_addr_ff != LAST)) begin
               rd_addr_in = rd_addr_ff + WA'(1);
            end
         end
         S_CHECK: begin
            if (scan_cmd) begin
               if (scan_res.hit) begin
                  map_we        = 1'b1;
                  res_grant_in  = IAR_GRANT_W'({chk_addr_ff, scan_res.pos});
                  res_status_in = ST_OK;
               end else if (chk_addr_ff == LAST) begin
                  res_grant_in  = '0;
                  res_status_in = ST_FULL;
               end else begin
                  // Advance the scan one word
                  chk_addr_in = chk_addr_ff + WA'(1);
                  if (rd_addr_ff != LAST) begin
                     rd_addr_in = rd_addr_ff + WA'(1);
                  end
               end
            end else if (used_word[bit_ff] && !rsv_word[bit_ff]) begin
               res_grant_in  = '0;
               res_status_in = (cmd_ff == CMD_CLAIM) ? ST_IN_USE : ST_RESERVE_USED;
            end else begin
               map_we        = 1'b1;
               res_grant_in  = IAR_GRANT_W'({chk_addr_ff, bit_ff});
               res_status_in = ST_OK;
            end
            if (map_we) begin
               vld_in[chk_addr_ff] = 1'b1;
            end
         end
         S_RESP: begin
            // Load the response beat once the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = IAR_RSP_W'({res_status_ff, res_grant_ff});
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rd_addr_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_addr_ff   <= rd_addr_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      chk_addr_ff   <= chk_addr_in;
      bit_ff        <= bit_in;
      res_grant_ff  <= res_grant_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rd_vld_ff     <= vld_ff[rd_addr_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `IAR_ASSERT_IMPLY(a_err_grant_zero,
      rsp_tvalid && (rsp_tdata[10:8] != ST_OK), rsp_tdata[7:0] == '0,
      "error response carries a nonzero index")
   `IAR_ASSERT_NEXT(a_busy_after_accept, req_accept, !req_tready,
      "accepted a second command while busy")
   `IAR_ASSERT_NEXT(a_resp_loads, (state_ff == S_RESP) && out_free,
      rsp_valid_ff && (state_ff == S_IDLE),
      "response not loaded on leaving the respond step")
   `IAR_ASSERT_ALWAYS(a_addr_bound,
      (32'(rd_addr_ff) < NW) && (32'(chk_addr_ff) < NW) || (state_ff == S_IDLE),
      "bitmap word address past the last word")
   `IAR_ASSERT_IMPLY(a_write_in_check, map_we, (state_ff == S_CHECK),
      "bitmap write outside the check step")

endmodule

### sv/iar_ram.sv
module iar_ram #(
   parameter  int WIDTH = 32,
   parameter  int DEPTH = 8,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/iar_ffz.sv
module iar_ffz #(
   parameter int CAPACITY = 256,
   parameter int WA       = 3
) (
   input  logic [WA-1:0]                  word_addr,
   input  logic [iar_pkg::IAR_WORD_W-1:0] used_word,
   output iar_pkg::scan_res_type          res
);
   import iar_pkg::*;

   logic [IAR_WORD_W-1:0] avail;

   // Mark free bits, treating indices past the capacity as taken
   always_comb begin
      for (int b = 0; b < IAR_WORD_W; b++) begin
         avail[b] = !used_word[b] &&
                    (32'({word_addr, IAR_BIT_W'(b)}) < 32'(CAPACITY));
      end
   end

   // Pick the lowest free bit
   always_comb begin
      res.hit = |avail;
      res.pos = '0;
      for (int b = IAR_WORD_W - 1; b >= 0; b--) begin
         if (avail[b]) begin
            res.pos = IAR_BIT_W'(b);
         end
      end
   end

endmodule

### test/alloc_grant_checker.sv
module alloc_grant_checker #(
   parameter int CAPACITY = iar_pkg::IAR_CAPACITY
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [iar_pkg::IAR_REQ_W-1:0] req_tdata,   // command[1:0], index[10:2]
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [iar_pkg::IAR_RSP_W-1:0] rsp_tdata,   // granted_index[7:0], status[10:8]
   output int                            fail_count,
   output int                            grants_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import iar_pkg::*;

   typedef struct packed {
      logic [IAR_GRANT_W-1:0] granted;
      status_type             status;
   } grant_beat_type;

   // Shadow copies of the used and reserved bitmaps
   logic [CAPACITY-1:0] taken_bits;
   logic [CAPACITY-1:0] held_bits;

   // Expected response beats, oldest first
   grant_beat_type grant_q[$];

   // Apply one command to the shadow bitmaps and return the response it earns
   function automatic grant_beat_type predict_grant(cmd_type cmd, logic [8:0] want);
      grant_beat_type beat;
      int             slot;
      beat.granted = '0;
      beat.status  = ST_OK;
      slot         = -1;
      if (cmd == CMD_CLAIM || cmd == CMD_RESERVE) begin
         if (want >= CAPACITY) begin
            beat.status = ST_RANGE;
         end else if (taken_bits[want] && !held_bits[want]) begin
            beat.status = (cmd == CMD_CLAIM) ? ST_IN_USE : ST_RESERVE_USED;
         end else begin
            // A claim of a reserved index drops the reservation
            slot             = int'(want);
            taken_bits[slot] = 1'b1;
            held_bits[slot]  = (cmd == CMD_RESERVE);
         end
      end else begin
         // Reserved indices count as used, so the search skips them
         for (int i = 0; i < CAPACITY && slot < 0; i++) begin
            if (!taken_bits[i]) slot = i;
         end
         if (slot < 0) begin
            beat.status = ST_FULL;
         end else begin
            taken_bits[slot] = 1'b1;
            if (cmd == CMD_RESERVE_FREE) held_bits[slot] = 1'b1;
         end
      end
      if (beat.status == ST_OK) beat.granted = IAR_GRANT_W'(slot);
      return beat;
   endfunction

   // Check response beats against the oldest prediction, then predict new ones
   always @(posedge clock) begin
      grant_beat_type oldest;
      logic [2:0]     got_status;
      if (reset) begin
         taken_bits = '0;
         held_bits  = '0;
         grant_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_status = rsp_tdata[IAR_GRANT_W +: 3];
            if (grant_q.size() == 0) begin
               fail_count++;
               $display("%0t: response beat with none pending: granted %0d status %0d",
                        $time, rsp_tdata[IAR_GRANT_W-1:0], got_status);
            end else begin
               oldest = grant_q.pop_front();
               if (rsp_tdata[IAR_GRANT_W-1:0] !== oldest.granted) begin
                  fail_count++;
                  $display("%0t: granted_index expected %0d actual %0d",
                           $time, oldest.granted, rsp_tdata[IAR_GRANT_W-1:0]);
               end
               if (got_status !== oldest.status) begin
                  fail_count++;
                  $display("%0t: status expected %0d (%s) actual %0d",
                           $time, oldest.status, oldest.status.name(), got_status);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            grant_q.push_back(predict_grant(cmd_type'(req_tdata[1:0]), req_tdata[10:2]));
         end
      end
      grants_pending <= grant_q.size();
   end

endmodule

### test/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import iar_pkg::*;

   localparam int RANDOM_ITEMS = 1200;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [IAR_REQ_W-1:0] req_tdata;    // command[1:0], index[10:2]
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [IAR_RSP_W-1:0] rsp_tdata;    // granted_index[7:0], status[10:8]

   int fail_count;
   int grants_pending;
   int burst_left;

   // Indices recently reserved by number, revisited to hit the reservation paths
   logic [8:0] reserve_pool[$];

   index_allocator_with_reservation_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   alloc_grant_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .fail_count     (fail_count),
      .grants_pending (grants_pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Offer one request beat and hold it until accepted; idle between bursts
   task automatic issue(input cmd_type cmd, input logic [8:0] want);
      req_tvalid <= 1'b1;
      req_tdata  <= IAR_REQ_W'({want, cmd});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
   endtask

   // Receiver: ready pattern in spans, with one long hold-off
   initial begin
      int mode;
      int span;
      int ticks;
      bit held_off;
      ticks    = 0;
      held_off = 1'b0;
      rsp_tready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (!held_off && ticks > 1500) begin
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            ticks += 400;
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(4, 60);
         repeat (span) begin
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ticks[0];
               default: rsp_tready <= ($urandom_range(0, 4) == 0);
            endcase
            @(posedge clock);
            ticks++;
         end
      end
   end

   // Stimulus and verdict
   initial begin
      cmd_type    cmd;
      logic [8:0] want;
      int         pick;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      reset      <= 1'b1;
      burst_left = $urandom_range(1, 24);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: range edges, in-use and reservation cases, the search
      issue(CMD_CLAIM, 9'd0);
      issue(CMD_CLAIM, 9'd0);
      issue(CMD_RESERVE, 9'd0);
      issue(CMD_RESERVE, 9'd5);
      issue(CMD_RESERVE, 9'd5);
      issue(CMD_CLAIM, 9'd5);
      issue(CMD_CLAIM, 9'd5);
      issue(CMD_RESERVE, 9'd5);
      issue(CMD_CLAIM, 9'd255);
      issue(CMD_CLAIM, 9'd256);
      issue(CMD_RESERVE, 9'd511);
      issue(CMD_CLAIM, 9'h1AA);
      issue(CMD_CLAIM, 9'h0AA);
      issue(CMD_RESERVE, 9'h055);
      issue(CMD_CLAIM_FREE, 9'h1FF);
      issue(CMD_RESERVE_FREE, 9'd0);
      issue(CMD_CLAIM, 9'd2);
      issue(CMD_RESERVE_FREE, 9'd0);
      issue(CMD_RESERVE, 9'd3);
      issue(CMD_CLAIM_FREE, 9'd0);
      issue(CMD_RESERVE, 9'd254);
      issue(CMD_CLAIM, 9'd254);

      // Random mix; no release exists, so the table fills and stays full
      repeat (RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         want = 9'($urandom_range(0, 511));
         if (pick < 12) begin
            cmd = CMD_CLAIM_FREE;
         end else if (pick < 24) begin
            cmd = CMD_RESERVE_FREE;
         end else if (pick < 85) begin
            cmd = (pick < 52) ? CMD_RESERVE : CMD_CLAIM;
            if (reserve_pool.size() > 0 && $urandom_range(0, 1))
               want = reserve_pool[$urandom_range(0, reserve_pool.size() - 1)];
            else
               want = 9'($urandom_range(0, 255));
            if (cmd == CMD_RESERVE) begin
               reserve_pool.push_back(want);
               if (reserve_pool.size() > 32) void'(reserve_pool.pop_front());
            end
         end else begin
            cmd  = $urandom_range(0, 1) ? CMD_RESERVE : CMD_CLAIM;
            want = 9'($urandom_range(256, 511));
         end
         issue(cmd, want);
      end

      // Drain outstanding responses
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (grants_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule

### sim.f
+incdir+sv
sv/iar_pkg.sv
sv/iar_ram.sv
sv/iar_ffz.sv
sv/index_allocator_with_reservation_core.sv
test/alloc_grant_checker.sv
test/tb_top.sv
